// ----- src/quaternion_to_transform_matrix_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion transform unit
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_TRANSFORM_MATRIX_UNIT_MACROS_SVH
`define QUATERNION_TO_TRANSFORM_MATRIX_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted
`define QTM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define QTM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QTM_ASSERT(lbl, clk, rst_n, prop, msg)
`define QTM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- src/qtm_pkg.sv -----
// ----------------------------------------------------------------------------
// qtm_pkg
// Widths, payload types and the entry reduction shared by the pipeline.
// ----------------------------------------------------------------------------
package qtm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int Q_W       = 16;
    localparam int POS_W     = 32;
    localparam int THR_W     = 15;
    localparam int OUT_W     = 16;
    localparam int PROD_W    = 2 * Q_W;
    localparam int NUM_ENT   = 9;
    // exact sums: doubled products or 1.0, two of them subtracted
    localparam int ACC_W     = ((2 * FRAC_BITS + 1 > PROD_W + 1) ?
                                (2 * FRAC_BITS + 1) : (PROD_W + 1)) + 2;

    // entry slots in the sum vector, row major
    localparam int E11 = 0;
    localparam int E12 = 1;
    localparam int E13 = 2;
    localparam int E21 = 3;
    localparam int E22 = 4;
    localparam int E23 = 5;
    localparam int E31 = 6;
    localparam int E32 = 7;
    localparam int E33 = 8;

    typedef struct packed {
        logic signed [Q_W-1:0]   q_w;
        logic signed [Q_W-1:0]   q_x;
        logic signed [Q_W-1:0]   q_y;
        logic signed [Q_W-1:0]   q_z;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] m11;
        logic signed [OUT_W-1:0] m12;
        logic signed [OUT_W-1:0] m13;
        logic signed [OUT_W-1:0] m21;
        logic signed [OUT_W-1:0] m22;
        logic signed [OUT_W-1:0] m23;
        logic signed [OUT_W-1:0] m31;
        logic signed [OUT_W-1:0] m32;
        logic signed [OUT_W-1:0] m33;
        logic signed [POS_W-1:0] t_x;
        logic signed [POS_W-1:0] t_y;
        logic signed [POS_W-1:0] t_z;
    } t_out_item;

    // raw (undoubled) component products
    typedef struct packed {
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] xz;
        logic signed [PROD_W-1:0] yz;
        logic signed [PROD_W-1:0] xw;
        logic signed [PROD_W-1:0] yw;
        logic signed [PROD_W-1:0] zw;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
    } t_prod;

    // exact entries with the rounding half already added
    typedef struct packed {
        logic [NUM_ENT-1:0][ACC_W-1:0] ent;
        logic signed [POS_W-1:0]       pos_x;
        logic signed [POS_W-1:0]       pos_y;
        logic signed [POS_W-1:0]       pos_z;
    } t_sum;

    // Drop the fraction, saturate to OUT_W bits, snap small magnitudes to zero.
    function automatic logic signed [OUT_W-1:0] qtm_finish(
        input logic signed [ACC_W-1:0] v,
        input logic [THR_W-1:0]        thr
    );
        logic signed [ACC_W-1:0] sh;
        logic signed [OUT_W-1:0] r;
        logic signed [OUT_W:0]   rx;
        logic [OUT_W:0]          mag;
        sh = v >>> FRAC_BITS;
        if ((&sh[ACC_W-1:OUT_W-1]) || !(|sh[ACC_W-1:OUT_W-1])) begin
            r = sh[OUT_W-1:0];
        end else if (sh[ACC_W-1]) begin
            r = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(OUT_W-1){1'b1}}};
        end
        rx  = {r[OUT_W-1], r};
        mag = rx[OUT_W] ? $unsigned(-rx) : $unsigned(rx);
        if (mag < (OUT_W+1)'(thr)) begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// ----- src/qtm_mul.sv -----
// ----------------------------------------------------------------------------
// qtm_mul
// Stage one: the nine component products, registered.
// ----------------------------------------------------------------------------
module qtm_mul
    import qtm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_valid,
    output t_prod    o_prod
);

    logic                     r_valid;
    t_prod                    r_prod;
    logic                     n_valid;
    t_prod                    n_prod;
    logic signed [PROD_W-1:0] ew, ex, ey, ez;

    always_comb begin
        ew = PROD_W'(i_item.q_w);
        ex = PROD_W'(i_item.q_x);
        ey = PROD_W'(i_item.q_y);
        ez = PROD_W'(i_item.q_z);
        n_valid      = i_valid;
        n_prod.xx    = ex * ex;
        n_prod.yy    = ey * ey;
        n_prod.zz    = ez * ez;
        n_prod.xy    = ex * ey;
        n_prod.xz    = ex * ez;
        n_prod.yz    = ey * ez;
        n_prod.xw    = ex * ew;
        n_prod.yw    = ey * ew;
        n_prod.zw    = ez * ew;
        n_prod.pos_x = i_item.pos_x;
        n_prod.pos_y = i_item.pos_y;
        n_prod.pos_z = i_item.pos_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

// ----- src/qtm_sum.sv -----
// ----------------------------------------------------------------------------
// qtm_sum
// Stage two: combine doubled products into the nine exact matrix entries.
// ----------------------------------------------------------------------------
module qtm_sum
    import qtm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_prod i_prod,
    output logic  o_valid,
    output t_sum  o_sum
);

    localparam logic signed [ACC_W-1:0] HALF_Q   = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] ONE_HALF = (ACC_W'(1) << (2 * FRAC_BITS)) + HALF_Q;

    logic                    r_valid;
    t_sum                    r_sum;
    logic                    n_valid;
    t_sum                    n_sum;
    logic signed [ACC_W-1:0] xx2, yy2, zz2, xy2, xz2, yz2, xw2, yw2, zw2;

    always_comb begin
        // sign extend, then double
        xx2 = ACC_W'(i_prod.xx) <<< 1;
        yy2 = ACC_W'(i_prod.yy) <<< 1;
        zz2 = ACC_W'(i_prod.zz) <<< 1;
        xy2 = ACC_W'(i_prod.xy) <<< 1;
        xz2 = ACC_W'(i_prod.xz) <<< 1;
        yz2 = ACC_W'(i_prod.yz) <<< 1;
        xw2 = ACC_W'(i_prod.xw) <<< 1;
        yw2 = ACC_W'(i_prod.yw) <<< 1;
        zw2 = ACC_W'(i_prod.zw) <<< 1;
        n_valid          = i_valid;
        n_sum.ent[E11]   = ONE_HALF - yy2 - zz2;
        n_sum.ent[E12]   = xy2 - zw2 + HALF_Q;
        n_sum.ent[E13]   = xz2 + yw2 + HALF_Q;
        n_sum.ent[E21]   = xy2 + zw2 + HALF_Q;
        n_sum.ent[E22]   = ONE_HALF - xx2 - zz2;
        n_sum.ent[E23]   = yz2 - xw2 + HALF_Q;
        n_sum.ent[E31]   = xz2 - yw2 + HALF_Q;
        n_sum.ent[E32]   = yz2 + xw2 + HALF_Q;
        n_sum.ent[E33]   = ONE_HALF - xx2 - yy2;
        n_sum.pos_x      = i_prod.pos_x;
        n_sum.pos_y      = i_prod.pos_y;
        n_sum.pos_z      = i_prod.pos_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;

endmodule

// ----- src/qtm_fin.sv -----
// ----------------------------------------------------------------------------
// qtm_fin
// Stage three: round, saturate and snap each entry; register the result.
// ----------------------------------------------------------------------------
module qtm_fin
    import qtm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_sum             i_sum,
    input  logic [THR_W-1:0] i_thr,
    output logic             o_valid,
    output t_out_item        o_result
);

    logic      r_valid;
    t_out_item r_result;
    logic      n_valid;
    t_out_item n_result;

    always_comb begin
        n_valid      = i_valid;
        n_result.m11 = qtm_finish($signed(i_sum.ent[E11]), i_thr);
        n_result.m12 = qtm_finish($signed(i_sum.ent[E12]), i_thr);
        n_result.m13 = qtm_finish($signed(i_sum.ent[E13]), i_thr);
        n_result.m21 = qtm_finish($signed(i_sum.ent[E21]), i_thr);
        n_result.m22 = qtm_finish($signed(i_sum.ent[E22]), i_thr);
        n_result.m23 = qtm_finish($signed(i_sum.ent[E23]), i_thr);
        n_result.m31 = qtm_finish($signed(i_sum.ent[E31]), i_thr);
        n_result.m32 = qtm_finish($signed(i_sum.ent[E32]), i_thr);
        n_result.m33 = qtm_finish($signed(i_sum.ent[E33]), i_thr);
        n_result.t_x = i_sum.pos_x;
        n_result.t_y = i_sum.pos_y;
        n_result.t_z = i_sum.pos_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- src/quaternion_to_transform_matrix_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_transform_matrix_unit
// A new pose can be started on every clock: busy stays low and a result strobes
// out on o_done, one per clock, in order, after passing through the three
// register stages (products, exact sums, round/saturate/snap). Results are held
// for one cycle only, so the receiver must take them as they come. Write the
// snap threshold only while no pose is in flight.
// ----------------------------------------------------------------------------
`include "quaternion_to_transform_matrix_unit_macros.svh"

module quaternion_to_transform_matrix_unit
    import qtm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_item,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_wdata,
    output logic             o_done,
    output t_out_item        o_result
);

    logic                    r_snap_thr;
    logic [THR_W-1:0]        r_thr;
    logic                    accept;
    logic                    mul_valid;
    t_prod                   mul_prod;
    logic                    sum_valid;
    t_sum                    sum_data;
    logic signed [OUT_W:0]   thr_s;
    logic signed [OUT_W:0]   m11_s;

    // the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= '0;
            r_snap_thr <= 1'b0;
        end else if (i_cfg_we) begin
            r_thr      <= i_cfg_wdata;
            r_snap_thr <= |i_cfg_wdata;
        end
    end

    qtm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .o_valid (mul_valid),
        .o_prod  (mul_prod)
    );

    qtm_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .i_prod  (mul_prod),
        .o_valid (sum_valid),
        .o_sum   (sum_data)
    );

    qtm_fin u_fin (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sum_valid),
        .i_sum    (sum_data),
        .i_thr    (r_thr),
        .o_valid  (o_done),
        .o_result (o_result)
    );

    assign thr_s = $signed((OUT_W+1)'(r_thr));
    assign m11_s = (OUT_W+1)'(o_result.m11);

    `QTM_ASSERT(a_latency, i_clk, i_rst_n, (accept |-> ##3 o_done), "accepted pose did not complete")
    `QTM_ASSERT(a_no_spurious, i_clk, i_rst_n, (o_done |-> $past(accept, 3)), "result without a pose")
    `QTM_ASSERT(a_snap, i_clk, i_rst_n, ((o_done && r_snap_thr) |-> (m11_s == 0 || m11_s >= thr_s || m11_s <= -thr_s)), "small entry not snapped")
    `QTM_ASSERT(a_thr_flag, i_clk, i_rst_n, (r_snap_thr == (|r_thr)), "threshold flag out of step")

endmodule

// ----- verif/quaternion_to_transform_matrix_unit_tb.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_transform_matrix_unit_tb
// Self-checking bench: drives poses through the start/busy port with random
// gaps, predicts most transforms in SV (exact products, round half up,
// saturate, snap by magnitude) and checks every o_done transfer field by field.
// The snap threshold is changed between phases once the pipe has drained.
// ----------------------------------------------------------------------------
module quaternion_to_transform_matrix_unit_tb;
    import qtm_pkg::*;

    localparam logic signed [15:0] Q_ONE = 16'sh4000;
    localparam logic signed [15:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [15:0] Q_MIN = 16'sh8000;
    localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] P_MIN = 32'sh8000_0000;
    localparam int PHASE_POSES = 150;

    typedef struct {
        logic [THR_W-1:0] thr;
        t_in_item         pose;
        bit               typed;
        t_out_item        want;
    } t_row;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_in_item         i_item      = '0;
    logic             i_cfg_we    = 1'b0;
    logic [THR_W-1:0] i_cfg_wdata = '0;
    logic             o_done;
    t_out_item        o_result;

    t_out_item        pending[$];
    t_row             rows[$];
    logic [THR_W-1:0] snap_now = '0;
    int               errors = 0;
    int               calm_left = 0;

    quaternion_to_transform_matrix_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Round half up to FRAC_BITS, clamp to 16 bits, zero small magnitudes.
    function automatic logic signed [15:0] reduce_entry(input longint exact,
                                                        input logic [THR_W-1:0] thr);
        longint r;
        longint mag;
        r = (exact + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        mag = (r < 0) ? -r : r;
        if (mag < longint'(thr)) r = 0;
        return r[15:0];
    endfunction

    function automatic t_out_item predict_transform(input t_in_item p,
                                                    input logic [THR_W-1:0] thr);
        longint w, x, y, z, one;
        longint xx, yy, zz, xy, xz, yz, xw, yw, zw;
        t_out_item r;
        w   = p.q_w;
        x   = p.q_x;
        y   = p.q_y;
        z   = p.q_z;
        one = longint'(1) <<< (2 * FRAC_BITS);
        xx  = 2 * x * x;
        yy  = 2 * y * y;
        zz  = 2 * z * z;
        xy  = 2 * x * y;
        xz  = 2 * x * z;
        yz  = 2 * y * z;
        xw  = 2 * x * w;
        yw  = 2 * y * w;
        zw  = 2 * z * w;
        r.m11 = reduce_entry(one - yy - zz, thr);
        r.m12 = reduce_entry(xy - zw, thr);
        r.m13 = reduce_entry(xz + yw, thr);
        r.m21 = reduce_entry(xy + zw, thr);
        r.m22 = reduce_entry(one - xx - zz, thr);
        r.m23 = reduce_entry(yz - xw, thr);
        r.m31 = reduce_entry(xz - yw, thr);
        r.m32 = reduce_entry(yz + xw, thr);
        r.m33 = reduce_entry(one - xx - yy, thr);
        r.t_x = p.pos_x;
        r.t_y = p.pos_y;
        r.t_z = p.pos_z;
        return r;
    endfunction

    function automatic t_in_item pose(input logic signed [15:0] w, x, y, z,
                                      input logic signed [31:0] px, py, pz);
        t_in_item p;
        p.q_w   = w;
        p.q_x   = x;
        p.q_y   = y;
        p.q_z   = z;
        p.pos_x = px;
        p.pos_y = py;
        p.pos_z = pz;
        return p;
    endfunction

    function automatic t_out_item mtx(input logic signed [15:0] a11, a12, a13,
                                      input logic signed [15:0] a21, a22, a23,
                                      input logic signed [15:0] a31, a32, a33,
                                      input logic signed [31:0] tx, ty, tz);
        t_out_item m;
        m.m11 = a11; m.m12 = a12; m.m13 = a13;
        m.m21 = a21; m.m22 = a22; m.m23 = a23;
        m.m31 = a31; m.m32 = a32; m.m33 = a33;
        m.t_x = tx;  m.t_y = ty;  m.t_z = tz;
        return m;
    endfunction

    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic signed [15:0] edge_comp();
        case ($urandom_range(0, 5))
            0:       return Q_MIN;
            1:       return -16'sd1;
            2:       return 16'sd0;
            3:       return 16'sd1;
            4:       return Q_ONE;
            default: return Q_MAX;
        endcase
    endfunction

    function automatic t_in_item random_pose();
        t_in_item p;
        real a, b, c, d, n;
        int mode;
        mode = $urandom_range(0, 9);
        p.pos_x = $urandom();
        p.pos_y = $urandom();
        p.pos_z = $urandom();
        if (mode <= 1) begin
            p.q_w = 16'($urandom());
            p.q_x = 16'($urandom());
            p.q_y = 16'($urandom());
            p.q_z = 16'($urandom());
        end else if (mode <= 5) begin
            // unit quaternion: scale a random direction to 1.0
            a = rand_span(-16384, 16384);
            b = rand_span(-16384, 16384);
            c = rand_span(-16384, 16384);
            d = rand_span(-16384, 16384);
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0) begin
                a = 1.0;
                n = 1.0;
            end
            p.q_w = 16'($rtoi(a * 16384.0 / n));
            p.q_x = 16'($rtoi(b * 16384.0 / n));
            p.q_y = 16'($rtoi(c * 16384.0 / n));
            p.q_z = 16'($rtoi(d * 16384.0 / n));
        end else if (mode <= 7) begin
            p.q_w = 16'(rand_span(-300, 300));
            p.q_x = 16'(rand_span(-300, 300));
            p.q_y = 16'(rand_span(-300, 300));
            p.q_z = 16'(rand_span(-300, 300));
        end else if (mode == 8) begin
            p.q_w = '0;
            p.q_x = '0;
            p.q_y = '0;
            p.q_z = '0;
            case ($urandom_range(0, 3))
                0:       p.q_w = edge_comp();
                1:       p.q_x = edge_comp();
                2:       p.q_y = edge_comp();
                default: p.q_z = edge_comp();
            endcase
        end else begin
            p.q_w = edge_comp();
            p.q_x = edge_comp();
            p.q_y = edge_comp();
            p.q_z = edge_comp();
        end
        return p;
    endfunction

    // Mostly random gaps, with runs of back-to-back transfers.
    function automatic int next_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    task automatic add_row(input logic [THR_W-1:0] thr, input t_in_item p,
                           input bit typed, input t_out_item want);
        t_row r;
        r.thr   = thr;
        r.pose  = p;
        r.typed = typed;
        r.want  = want;
        rows.insert(rows.size(), r);
    endtask

    // Hold start until the transfer, then queue the expected transform.
    task automatic send_pose(input t_in_item p, input t_out_item want, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending.insert(pending.size(), want);
    endtask

    task automatic set_snap(input logic [THR_W-1:0] thr);
        start <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        snap_now = thr;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending.size() == 0) begin
                $error("result transfer with no pose pending");
                errors++;
            end else begin
                want = pending.pop_front();
                check_field("m11", want.m11, o_result.m11);
                check_field("m12", want.m12, o_result.m12);
                check_field("m13", want.m13, o_result.m13);
                check_field("m21", want.m21, o_result.m21);
                check_field("m22", want.m22, o_result.m22);
                check_field("m23", want.m23, o_result.m23);
                check_field("m31", want.m31, o_result.m31);
                check_field("m32", want.m32, o_result.m32);
                check_field("m33", want.m33, o_result.m33);
                check_field("t_x", want.t_x, o_result.t_x);
                check_field("t_y", want.t_y, o_result.t_y);
                check_field("t_z", want.t_z, o_result.t_z);
            end
        end
    end

    initial begin : stimulus
        t_in_item p;
        t_out_item want;
        logic [THR_W-1:0] thr_plan[$];

        // identity and zero quaternions, extremes of each component
        add_row(0, pose(0, 0, 0, 0, 0, 0, 0), 1,
                mtx(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0));
        add_row(0, pose(Q_ONE, 0, 0, 0, P_MAX, P_MAX, P_MAX), 1,
                mtx(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, P_MAX, P_MAX, P_MAX));
        add_row(0, pose(Q_MIN, 0, 0, 0, P_MIN, P_MIN, P_MIN), 1,
                mtx(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, P_MIN, P_MIN, P_MIN));
        add_row(0, pose(0, Q_MIN, 0, 0, -1, 0, 1), 1,
                mtx(Q_ONE, 0, 0, 0, Q_MIN, 0, 0, 0, Q_MIN, -1, 0, 1));
        add_row(0, pose(0, 0, Q_MAX, 0, 32'h5555_5555, 32'hAAAA_AAAA, 0), 0, '0);
        add_row(0, pose(0, 0, 0, Q_MIN, 32'hAAAA_AAAA, 32'h5555_5555, -1), 0, '0);
        add_row(0, pose(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1, 2, 3), 0, '0);
        add_row(0, pose(Q_MIN, Q_MIN, Q_MIN, Q_MIN, -3, -2, -1), 0, '0);
        add_row(0, pose(-1, -1, -1, -1, 0, 0, 0), 0, '0);
        add_row(0, pose(11585, 0, 0, 11585, 100, 200, 300), 0, '0);
        add_row(0, pose(0, Q_ONE, 0, 0, 0, 0, 0), 0, '0);
        // exact halves: one rounds up, the negative one rounds to zero
        add_row(0, pose(0, 1, 4096, 0, 0, 0, 0), 0, '0);
        add_row(0, pose(0, 1, -4096, 0, 0, 0, 0), 0, '0);
        add_row(0, pose(9459, -9459, 9459, -9459, 7, 8, 9), 0, '0);
        // snapping by magnitude; full-scale negatives always survive
        add_row(16384, pose(Q_ONE, 0, 0, 0, 0, 0, 0), 1,
                mtx(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0));
        add_row(16384, pose(0, Q_MIN, 0, 0, 0, 0, 0), 1,
                mtx(Q_ONE, 0, 0, 0, Q_MIN, 0, 0, 0, Q_MIN, 0, 0, 0));
        add_row(16384, pose(11585, 0, 0, 11585, 0, 0, 0), 0, '0);
        add_row(1, pose(0, 1, 4096, 0, 0, 0, 0), 0, '0);
        add_row(2, pose(0, 1, 4096, 0, 0, 0, 0), 0, '0);
        add_row(32767, pose(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0), 0, '0);
        add_row(32767, pose(0, Q_MIN, 0, 0, 0, 0, 0), 1,
                mtx(0, 0, 0, 0, Q_MIN, 0, 0, 0, Q_MIN, 0, 0, 0));
        add_row(12000, pose(11585, 0, 0, 11585, 0, 0, 0), 0, '0);
        add_row(12000, pose(0, -11585, 0, 11585, 0, 0, 0), 0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].thr != snap_now) set_snap(rows[i].thr);
            want = rows[i].typed ? rows[i].want : predict_transform(rows[i].pose, snap_now);
            send_pose(rows[i].pose, want, next_gap());
        end

        thr_plan = '{0, 15'(rand_span(1, 64)), 16384, 15'(rand_span(0, 16384)), 32767,
                     15'(rand_span(8000, 16384)), 15'(rand_span(1, 2048)), 0,
                     15'(rand_span(0, 16384)), 16383, 15'(rand_span(16385, 32767))};
        foreach (thr_plan[k]) begin
            set_snap(thr_plan[k]);
            repeat (PHASE_POSES) begin
                p = random_pose();
                send_pose(p, predict_transform(p, snap_now), next_gap());
            end
        end

        start <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        // catch any stray transfer after the last expected one
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("[quaternion_to_transform_matrix_unit] OK");
        end else begin
            $display("[quaternion_to_transform_matrix_unit] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("[quaternion_to_transform_matrix_unit] ERROR");
        $finish;
    end

endmodule
